@@ hdl/format_directive_expander_macros.svh @@
// Assertion macros shared by the format directive expander modules
`ifndef FORMAT_DIRECTIVE_EXPANDER_MACROS_SVH
`define FORMAT_DIRECTIVE_EXPANDER_MACROS_SVH

`ifndef SYNTHESIS
`define FDE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define FDE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define FDE_ASSERT_SAME(lbl, ante, cons, msg)
`define FDE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ hdl/fde_pkg.sv @@
// Types, constants and helper functions of the format directive expander
package fde_pkg;

  localparam int ARG_WIDTH_DEF = 32;
  localparam int CHAR_W        = 8;
  localparam int WORD_W        = 32;
  localparam int IN_DATA_W     = CHAR_W + WORD_W;
  localparam int OUT_DATA_W    = CHAR_W + WORD_W;
  localparam int DIGIT_W       = 4;

  localparam logic [CHAR_W-1:0] CHAR_PERCENT = 8'h25;
  localparam logic [CHAR_W-1:0] CHAR_B       = 8'h62;
  localparam logic [CHAR_W-1:0] CHAR_C       = 8'h63;
  localparam logic [CHAR_W-1:0] CHAR_D       = 8'h64;
  localparam logic [CHAR_W-1:0] CHAR_X       = 8'h78;
  localparam logic [CHAR_W-1:0] CHAR_P       = 8'h70;
  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_ALPHA   = 8'h37;

  localparam logic [WORD_W-1:0] RECIP10      = 32'hCCCCCCCD;
  localparam int                RECIP10_SH   = 35;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT,
    ST_ESC
  } fde_state_t;

  typedef enum logic [2:0] {
    CLS_PERCENT,
    CLS_BIN,
    CLS_DEC,
    CLS_HEX,
    CLS_CHR,
    CLS_OTHER
  } fde_cls_t;

  typedef enum logic [1:0] {
    BASE_2,
    BASE_10,
    BASE_16
  } fde_base_t;

  typedef enum logic [2:0] {
    SRC_NONE,
    SRC_FMT,
    SRC_ARG,
    SRC_PCT,
    SRC_HELD,
    SRC_DIGIT
  } fde_src_t;

  typedef struct packed {
    fde_src_t src;
    logic     last;
    logic     load;
    logic     conv;
    logic     pop;
  } fde_cmd_t;

  typedef struct packed {
    fde_cls_t cls;
    logic     quot_zero;
    logic     idx_one;
    logic     out_free;
  } fde_sts_t;

  function automatic fde_cls_t classify(input logic [CHAR_W-1:0] ch);
    fde_cls_t c;
    case (ch)
      CHAR_PERCENT: c = CLS_PERCENT;
      CHAR_B:       c = CLS_BIN;
      CHAR_D:       c = CLS_DEC;
      CHAR_X:       c = CLS_HEX;
      CHAR_P:       c = CLS_HEX;
      CHAR_C:       c = CLS_CHR;
      default:      c = CLS_OTHER;
    endcase
    return c;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] r;
    if (d < 4'd10) begin
      r = CHAR_ZERO + {4'b0, d};
    end else begin
      r = CHAR_ALPHA + {4'b0, d};
    end
    return r;
  endfunction

endpackage

@@ hdl/format_directive_expander.sv @@
// Top level of the format directive expander
// Usage:
//   Input channel in_*: one format character per item with an argument word.
//   A plain character is echoed, '%' arms a directive and emits nothing, and
//   the character after '%' picks b, d, x/p (number in base 2, 10, 16),
//   c (argument low byte), '%' (a percent) or anything else ('%' then it).
//   Output channel out_*: one item per emitted character; out_tlast marks the
//   last character that an input item produces, and the running character
//   count travels beside each character.
//   A single-character result is in the output register the cycle after its
//   item is accepted. A number is divided down in the digit unit, one divide
//   step per cycle, each digit pushed onto the digit stack; the stack is then
//   popped, most significant digit first, into the output register, each pop
//   waiting for the output register to be free.
//   Throughput: one input item at a time; the next is taken once the current
//   one has handed its last character to the output register.
//   Reset clears the pending directive, the character count and the output.
//   A stall on out_tready holds the output item and halts input and output.
module format_directive_expander #(
  parameter int ARG_WIDTH = fde_pkg::ARG_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [7:0] fmt_char, [39:8] arg_value
  input  logic [fde_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [7:0] out_char, [39:8] written_so_far
  output logic [fde_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tlast
);
  import fde_pkg::*;

  fde_cmd_t cmd;
  fde_sts_t sts;

  fde_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fde_dp #(
    .ARG_WIDTH (ARG_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );
endmodule

@@ hdl/fde_ctrl.sv @@
// Controller state machine of the format directive expander
`include "format_directive_expander_macros.svh"
module fde_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  fde_pkg::fde_sts_t sts,
  output fde_pkg::fde_cmd_t cmd
);
  import fde_pkg::*;

  fde_state_t state_r, state_nxt;
  logic       pend_r, pend_nxt;
  logic       acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    pend_nxt  = pend_r;
    in_tready = 1'b0;
    acc       = 1'b0;
    cmd       = '{src: SRC_NONE, last: 1'b0, load: 1'b0, conv: 1'b0, pop: 1'b0};
    case (state_r)
      ST_IDLE: begin
        in_tready = sts.out_free;
        acc       = in_tvalid && sts.out_free;
        if (acc) begin
          if (!pend_r) begin
            if (sts.cls == CLS_PERCENT) begin
              pend_nxt = 1'b1;
            end else begin
              cmd.src  = SRC_FMT;
              cmd.last = 1'b1;
            end
          end else begin
            pend_nxt = 1'b0;
            case (sts.cls)
              CLS_BIN, CLS_DEC, CLS_HEX: begin
                cmd.load  = 1'b1;
                state_nxt = ST_CONV;
              end
              CLS_CHR: begin
                cmd.src  = SRC_ARG;
                cmd.last = 1'b1;
              end
              CLS_PERCENT: begin
                cmd.src  = SRC_PCT;
                cmd.last = 1'b1;
              end
              default: begin
                cmd.src   = SRC_PCT;
                cmd.load  = 1'b1;
                state_nxt = ST_ESC;
              end
            endcase
          end
        end
      end
      ST_CONV: begin
        cmd.conv = 1'b1;
        if (sts.quot_zero) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.src  = SRC_DIGIT;
          cmd.last = sts.idx_one;
          cmd.pop  = 1'b1;
          if (sts.idx_one) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_ESC: begin
        if (sts.out_free) begin
          cmd.src   = SRC_HELD;
          cmd.last  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `FDE_ASSERT_SAME(a_ready_idle, in_tready, state_r == ST_IDLE && sts.out_free, "ready outside idle")
  `FDE_ASSERT_NEXT(a_conv_done, state_r == ST_CONV && sts.quot_zero, state_r == ST_EMIT, "conversion did not finish")
  `FDE_ASSERT_NEXT(a_pend_clear, acc && pend_r, !pend_r, "pending percent not cleared")
endmodule

@@ hdl/fde_dp.sv @@
// Datapath of the format directive expander: digit unit, digit stack and output register
`include "format_directive_expander_macros.svh"
module fde_dp #(
  parameter int ARG_WIDTH = fde_pkg::ARG_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [fde_pkg::IN_DATA_W-1:0]  in_tdata,
  input  fde_pkg::fde_cmd_t              cmd,
  output fde_pkg::fde_sts_t              sts,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [fde_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tlast
);
  import fde_pkg::*;

  localparam int VAL_W  = (ARG_WIDTH < WORD_W) ? ARG_WIDTH : WORD_W;
  localparam int IDX_W  = $clog2(VAL_W + 1);
  localparam int ADDR_W = $clog2(VAL_W);

  logic [VAL_W-1:0]   val_r;
  fde_base_t          base_r;
  logic [CHAR_W-1:0]  held_r;
  logic [IDX_W-1:0]   idx_r;
  logic [DIGIT_W-1:0] dig_mem [VAL_W];

  logic               out_valid_r;
  logic               out_last_r;
  logic [CHAR_W-1:0]  out_char_r;
  logic [WORD_W-1:0]  out_cnt_r;
  logic [WORD_W-1:0]  cnt_r, cnt_nxt;

  logic [CHAR_W-1:0]  in_char;
  logic [VAL_W-1:0]   in_val;
  logic [WORD_W-1:0]  val32;
  logic [63:0]        prod;
  logic [WORD_W-1:0]  q10;
  logic [WORD_W-1:0]  r10;
  logic [VAL_W-1:0]   quot;
  logic [DIGIT_W-1:0] digit;
  logic [IDX_W-1:0]   rd_idx;
  logic [CHAR_W-1:0]  emit_char;
  logic               emit;
  logic               out_free;

  assign in_char  = in_tdata[CHAR_W-1:0];
  assign in_val   = in_tdata[CHAR_W +: VAL_W];
  assign val32    = WORD_W'(val_r);
  assign prod     = 64'(val32) * 64'(RECIP10);
  assign q10      = WORD_W'(prod >> RECIP10_SH);
  assign r10      = val32 - (q10 << 3) - (q10 << 1);
  assign rd_idx   = idx_r - IDX_W'(1);
  assign out_free = !out_valid_r || out_tready;
  assign emit     = cmd.src != SRC_NONE;
  assign cnt_nxt  = cnt_r + WORD_W'(1);

  always_comb begin
    case (base_r)
      BASE_2: begin
        digit = {3'b0, val_r[0]};
        quot  = val_r >> 1;
      end
      BASE_10: begin
        digit = r10[DIGIT_W-1:0];
        quot  = VAL_W'(q10);
      end
      BASE_16: begin
        digit = val_r[DIGIT_W-1:0];
        quot  = val_r >> DIGIT_W;
      end
      default: begin
        digit = '0;
        quot  = '0;
      end
    endcase
  end

  always_comb begin
    case (cmd.src)
      SRC_FMT:   emit_char = in_char;
      SRC_ARG:   emit_char = in_tdata[CHAR_W +: CHAR_W];
      SRC_PCT:   emit_char = CHAR_PERCENT;
      SRC_HELD:  emit_char = held_r;
      default:   emit_char = '0;
    endcase
  end

  always_comb begin
    sts.cls       = classify(in_char);
    sts.quot_zero = quot == '0;
    sts.idx_one   = idx_r == IDX_W'(1);
    sts.out_free  = out_free;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val_r  <= in_val;
      held_r <= in_char;
      case (classify(in_char))
        CLS_BIN: base_r <= BASE_2;
        CLS_DEC: base_r <= BASE_10;
        default: base_r <= BASE_16;
      endcase
    end else if (cmd.conv) begin
      val_r <= quot;
    end
    if (cmd.conv) begin
      dig_mem[idx_r[ADDR_W-1:0]] <= digit;
    end
    if (emit) begin
      if (cmd.src == SRC_DIGIT) begin
        out_char_r <= digit_char(dig_mem[rd_idx[ADDR_W-1:0]]);
      end else begin
        out_char_r <= emit_char;
      end
      out_last_r <= cmd.last;
      out_cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        idx_r <= '0;
      end else if (cmd.conv) begin
        idx_r <= idx_r + IDX_W'(1);
      end else if (cmd.pop) begin
        idx_r <= rd_idx;
      end
      if (emit) begin
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {out_cnt_r, out_char_r};

  `FDE_ASSERT_SAME(a_emit_free, emit, out_free, "item emitted into a full output register")
  `FDE_ASSERT_NEXT(a_count_step, emit, cnt_r == $past(cnt_r) + WORD_W'(1), "count did not advance")
  `FDE_ASSERT_SAME(a_idx_range, cmd.conv || cmd.pop, idx_r <= IDX_W'(VAL_W), "digit index overrun")
endmodule
